/* src/dwag_pkg.sv */
// Shared types and constants of the distance window acceptance gate.
// Used by the controller, the datapath and the top level; depends on nothing.
package dwag_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PATH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FGRAD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YGRAD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTL  = 3'd7;

  localparam logic [1:0] DEC_MONITOR  = 2'd0;
  localparam logic [1:0] DEC_REJECTED = 2'd1;
  localparam logic [1:0] DEC_ACCEPTED = 2'd2;
  localparam logic [1:0] DEC_LATCHED  = 2'd3;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear;
    logic ovf_drop;
    logic push;
    logic trim_drop;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic bypass;
    logic full;
    logic cnt_gt1;
    logic trim_hit;
    logic out_free;
  } status_t;

endpackage

/* src/dwag_ctrl.sv */
// Controller state machine of the distance window acceptance gate.
// Depends on dwag_pkg for the command and status structs.
module dwag_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dwag_pkg::status_t sts,
  output dwag_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_OVF, S_PUSH, S_TRIM_RD, S_TRIM_CMP, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.restart) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.bypass) begin
          state_nxt = S_OUT;
        end else if (sts.full) begin
          state_nxt = S_OVF;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_OVF: begin
        cmd.ovf_drop = 1'b1;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_TRIM_RD;
      end
      S_TRIM_RD: begin
        state_nxt = sts.cnt_gt1 ? S_TRIM_CMP : S_OUT;
      end
      S_TRIM_CMP: begin
        if (sts.trim_hit) begin
          cmd.trim_drop = 1'b1;
          state_nxt     = S_TRIM_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* src/dwag_dp.sv */
// Datapath of the distance window acceptance gate: registers, ring memory,
// counters and result register. Depends on dwag_pkg.
module dwag_dp #(
  parameter int unsigned DEPTH   = 64,
  parameter int unsigned MIN_OBS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dwag_pkg::cmd_t                  cmd,
  output dwag_pkg::status_t               sts,
  input  logic                            cfg_we,
  input  logic [dwag_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dwag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_op,
  input  logic [31:0]                     in_frame_id,
  input  logic [31:0]                     in_distance_mm,
  input  logic [15:0]                     in_position_residual,
  input  logic [15:0]                     in_yaw_residual,
  input  logic [15:0]                     in_velocity_error,
  input  logic                            in_baseline_available,
  input  logic                            in_guard_on,
  input  logic [15:0]                     in_field_gradient,
  input  logic [15:0]                     in_yaw_gradient,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_frame_id_out,
  output logic [1:0]                      out_decision,
  output logic                            out_is_accepted,
  output logic                            out_just_changed,
  output logic [31:0]                     out_start_frame_id,
  output logic [6:0]                      out_window_count,
  output logic [31:0]                     out_path_length_mm,
  output logic [6:0]                      out_valid_count,
  output logic                            out_overflowed
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = CW + 17;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);

  logic        en_r;
  logic [19:0] min_path_r;
  logic [15:0] max_pos_r, max_yaw_r, max_vel_r, max_fgrad_r, max_ygrad_r;
  logic [14:0] max_outl_r;

  logic        op_r, base_r, guard_r;
  logic [31:0] fid_r, dist_r;
  logic [15:0] pos_r, yaw_r, vel_r, fgrad_r, ygrad_r;

  logic [AW-1:0] head_r;
  logic [CW-1:0] cnt_r, vtot_r, size_r;
  logic          latched_r, ovf_r;
  logic [31:0]   start_id_r, start_dist_r;
  logic [31:0]   head_id_r, head_dist_r;
  logic          head_vld_r;

  logic [64:0]   mem [DEPTH];
  logic [64:0]   rd_r;

  logic          sample_ok;
  logic [AW-1:0] head_p1, wslot;
  logic [AW:0]   sum_p1, sum_w;
  logic [32:0]   trim_lim;
  logic [CW-1:0] vtot_dec;
  logic [PW-1:0] lhs, rhs;
  logic [16:0]   keep_frac;
  logic [31:0]   path;
  logic          accept_now;

  assign sample_ok = base_r && guard_r && (pos_r <= max_pos_r) && (yaw_r <= max_yaw_r) &&
                     (vel_r <= max_vel_r) && (fgrad_r <= max_fgrad_r) &&
                     (ygrad_r <= max_ygrad_r);

  assign sum_p1  = {1'b0, head_r} + (AW + 1)'(1);
  assign head_p1 = (sum_p1 >= DEPTH_A) ? AW'(sum_p1 - DEPTH_A) : AW'(sum_p1);
  assign sum_w   = {1'b0, head_r} + (AW + 1)'(cnt_r);
  assign wslot   = (sum_w >= DEPTH_A) ? AW'(sum_w - DEPTH_A) : AW'(sum_w);

  assign trim_lim = {1'b0, rd_r[31:0]} + 33'(min_path_r);
  assign vtot_dec = (head_vld_r && vtot_r != '0) ? vtot_r - CW'(1) : vtot_r;

  assign keep_frac  = 17'h10000 - 17'(max_outl_r);
  assign lhs        = PW'({vtot_r, 16'h0000});
  assign rhs        = PW'(keep_frac) * PW'(cnt_r);
  assign path       = (dist_r >= head_dist_r) ? dist_r - head_dist_r : 32'd0;
  assign accept_now = (32'(cnt_r) >= 32'(MIN_OBS)) && (path >= 32'(min_path_r)) &&
                      (lhs >= rhs) && sample_ok;

  assign sts.restart  = (op_r == dwag_pkg::OP_RESTART);
  assign sts.bypass   = !en_r || latched_r;
  assign sts.full     = (cnt_r >= DEPTH_C);
  assign sts.cnt_gt1  = (cnt_r > CW'(1));
  assign sts.trim_hit = ({1'b0, dist_r} >= trim_lim);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b1;
      min_path_r  <= 20'd10000;
      max_pos_r   <= 16'd500;
      max_yaw_r   <= 16'd500;
      max_vel_r   <= 16'd300;
      max_fgrad_r <= 16'd50;
      max_ygrad_r <= 16'd500;
      max_outl_r  <= 15'd6554;
    end else if (cfg_we) begin
      case (cfg_addr)
        dwag_pkg::REG_ENABLED:   en_r        <= cfg_wdata[0];
        dwag_pkg::REG_MIN_PATH:  min_path_r  <= cfg_wdata;
        dwag_pkg::REG_MAX_POS:   max_pos_r   <= cfg_wdata[15:0];
        dwag_pkg::REG_MAX_YAW:   max_yaw_r   <= cfg_wdata[15:0];
        dwag_pkg::REG_MAX_VEL:   max_vel_r   <= cfg_wdata[15:0];
        dwag_pkg::REG_MAX_FGRAD: max_fgrad_r <= cfg_wdata[15:0];
        dwag_pkg::REG_MAX_YGRAD: max_ygrad_r <= cfg_wdata[15:0];
        dwag_pkg::REG_MAX_OUTL:  max_outl_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      fid_r   <= in_frame_id;
      dist_r  <= in_distance_mm;
      pos_r   <= in_position_residual;
      yaw_r   <= in_yaw_residual;
      vel_r   <= in_velocity_error;
      base_r  <= in_baseline_available;
      guard_r <= in_guard_on;
      fgrad_r <= in_field_gradient;
      ygrad_r <= in_yaw_gradient;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) mem[wslot] <= {sample_ok, fid_r, dist_r};
    rd_r <= mem[head_p1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      head_r       <= '0;
      cnt_r        <= '0;
      vtot_r       <= '0;
      size_r       <= '0;
      latched_r    <= 1'b0;
      start_id_r   <= '0;
      start_dist_r <= '0;
      ovf_r        <= 1'b0;
    end else begin
      if (cmd.capture) ovf_r <= 1'b0;
      if (cmd.ovf_drop || cmd.trim_drop) begin
        vtot_r      <= vtot_dec;
        head_r      <= head_p1;
        cnt_r       <= cnt_r - CW'(1);
        head_id_r   <= rd_r[63:32];
        head_dist_r <= rd_r[31:0];
        head_vld_r  <= rd_r[64];
        if (cmd.ovf_drop) ovf_r <= 1'b1;
      end
      if (cmd.push) begin
        cnt_r <= cnt_r + CW'(1);
        if (sample_ok) vtot_r <= vtot_r + CW'(1);
        if (cnt_r == '0) begin
          head_id_r   <= fid_r;
          head_dist_r <= dist_r;
          head_vld_r  <= sample_ok;
        end
      end
      if (cmd.load_out && en_r && !latched_r) begin
        start_id_r   <= head_id_r;
        start_dist_r <= head_dist_r;
        size_r       <= cnt_r;
        if (accept_now) latched_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_frame_id_out   <= fid_r;
      out_decision       <= dwag_pkg::DEC_MONITOR;
      out_is_accepted    <= 1'b0;
      out_just_changed   <= 1'b0;
      out_start_frame_id <= '0;
      out_window_count   <= '0;
      out_path_length_mm <= '0;
      out_valid_count    <= '0;
      out_overflowed     <= 1'b0;
      if (en_r && latched_r) begin
        out_decision       <= dwag_pkg::DEC_LATCHED;
        out_is_accepted    <= 1'b1;
        out_start_frame_id <= start_id_r;
        out_window_count   <= 7'(size_r);
        out_path_length_mm <= (dist_r >= start_dist_r) ? dist_r - start_dist_r : 32'd0;
      end else if (en_r) begin
        if (accept_now) begin
          out_decision <= dwag_pkg::DEC_ACCEPTED;
        end else begin
          out_decision <= sample_ok ? dwag_pkg::DEC_MONITOR : dwag_pkg::DEC_REJECTED;
        end
        out_is_accepted    <= accept_now;
        out_just_changed   <= accept_now;
        out_start_frame_id <= head_id_r;
        out_window_count   <= 7'(cnt_r);
        out_path_length_mm <= path;
        out_valid_count    <= 7'(vtot_r);
        out_overflowed     <= ovf_r;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("window count beyond depth");

  a_vtot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vtot_r <= cnt_r) else $error("valid total beyond window count");

  a_drop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.trim_drop || cmd.ovf_drop) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("drop did not shrink the window");

  a_trim_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trim_drop |-> (cnt_r > CW'(1))) else $error("trim emptied the window");

endmodule

/* src/distance_window_acceptance_gate.sv */
// Top level of the distance window acceptance gate.
// Joins dwag_ctrl and dwag_dp; uses dwag_pkg for shared types.
//
// One item is taken at a time. An observation is captured and decided on;
// when the ring is full the oldest entry is dropped first. It is then
// pushed, and head entries are trimmed while the window holds more than one
// entry and the path from the next entry still reaches the minimum; every
// trim step waits on a registered read of the ring memory. Disabled or
// latched observations go straight to the result; a restart clears the
// window. The result register lets the next item be taken while a result
// still waits, and a result waits for it to be free before it is loaded.
module distance_window_acceptance_gate #(
  parameter int unsigned WINDOW_DEPTH     = 64,
  parameter int unsigned MIN_OBSERVATIONS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dwag_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dwag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [31:0]                     in_frame_id,
  input  logic [31:0]                     in_distance_mm,
  input  logic [15:0]                     in_position_residual,
  input  logic [15:0]                     in_yaw_residual,
  input  logic [15:0]                     in_velocity_error,
  input  logic                            in_baseline_available,
  input  logic                            in_guard_on,
  input  logic [15:0]                     in_field_gradient,
  input  logic [15:0]                     in_yaw_gradient,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_frame_id_out,
  output logic [1:0]                      out_decision,
  output logic                            out_is_accepted,
  output logic                            out_just_changed,
  output logic [31:0]                     out_start_frame_id,
  output logic [6:0]                      out_window_count,
  output logic [31:0]                     out_path_length_mm,
  output logic [6:0]                      out_valid_count,
  output logic                            out_overflowed
);

  dwag_pkg::cmd_t    cmd;
  dwag_pkg::status_t sts;

  dwag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwag_dp #(
    .DEPTH   (WINDOW_DEPTH),
    .MIN_OBS (MIN_OBSERVATIONS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .in_op                 (in_op),
    .in_frame_id           (in_frame_id),
    .in_distance_mm        (in_distance_mm),
    .in_position_residual  (in_position_residual),
    .in_yaw_residual       (in_yaw_residual),
    .in_velocity_error     (in_velocity_error),
    .in_baseline_available (in_baseline_available),
    .in_guard_on           (in_guard_on),
    .in_field_gradient     (in_field_gradient),
    .in_yaw_gradient       (in_yaw_gradient),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_frame_id_out      (out_frame_id_out),
    .out_decision          (out_decision),
    .out_is_accepted       (out_is_accepted),
    .out_just_changed      (out_just_changed),
    .out_start_frame_id    (out_start_frame_id),
    .out_window_count      (out_window_count),
    .out_path_length_mm    (out_path_length_mm),
    .out_valid_count       (out_valid_count),
    .out_overflowed        (out_overflowed)
  );

endmodule
